FILE: hw/rtl/swmm_pkg.sv
// swmm_pkg: shared constants, types and the back-end state encoding
// for the sliding-window median and mean filter; no dependencies
`default_nettype none

package swmm_pkg;

  localparam int DEF_WINDOW_DEPTH = 8;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int QUEUE_DEPTH      = 2;

  // occupancy flags of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_PREP,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_median_mean.sv
// Sliding-window median and mean filter.
// Input channel: in_valid / in_stall / in_sample, one signed Q8.8 sample per beat.
// Output channel: out_valid / out_stall and one result per input beat: median,
// mean (truncated toward zero), echoed sample, fill count and dropped flag.
// The window holds the newest WINDOW_DEPTH samples; the oldest is overwritten
// once it is full. The median is the sorted element at index count/2.
// A front end tracks the ring slot and fill count and pushes each beat into a
// two-entry queue; a back end updates the window and computes the result.
// The back end scans the window by rank, one candidate per cycle against every
// slot, one candidate per filled slot, then computes the mean in a divider that
// yields one quotient bit per cycle, MAG = SAMPLE_BITS + clog2(WINDOW_DEPTH+1) - 1
// quotient bits in all (19 with the defaults).
// The front keeps accepting until the queue is full, then raises in_stall.
// A result waiting under out_stall holds; the back end finishes the next beat
// and waits for the output register to free.
// Synchronous active-low reset empties the window and the queue and drops any
// pending result; window contents are not cleared.
`default_nettype none

module sliding_window_median_mean #(
  parameter int WINDOW_DEPTH = swmm_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = swmm_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_median_value,
  output logic signed [SAMPLE_BITS-1:0]               out_mean_value,
  output logic signed [SAMPLE_BITS-1:0]               out_latest_sample,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]           out_window_count,
  output logic                                        out_dropped_oldest
);
  import swmm_pkg::*;

  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ENTRY_W = SAMPLE_BITS + SLOT_W + CNT_W + 1;

  fifo_stat_t          q_stat;
  logic                q_push, q_pop;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;

  swmm_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .SLOT_W       (SLOT_W),
    .CNT_W        (CNT_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .stat      (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  swmm_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  swmm_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .SLOT_W       (SLOT_W),
    .CNT_W        (CNT_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .stat               (q_stat),
    .pop                (q_pop),
    .pop_data           (q_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_value   (out_median_value),
    .out_mean_value     (out_mean_value),
    .out_latest_sample  (out_latest_sample),
    .out_window_count   (out_window_count),
    .out_dropped_oldest (out_dropped_oldest)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/swmm_fifo.sv
// swmm_fifo: short queue that carries classified samples from front to back
// depends on swmm_pkg (QUEUE_DEPTH, fifo_stat_t)
`default_nettype none

module swmm_fifo #(
  parameter int DATA_W = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [DATA_W-1:0]  push_data,
  input  wire logic               pop,
  output logic [DATA_W-1:0]       pop_data,
  output swmm_pkg::fifo_stat_t    stat
);
  import swmm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_data   = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("swmm_fifo: push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("swmm_fifo: pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("swmm_fifo: occupancy out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/swmm_front.sv
// swmm_front: accepts samples and does the ring bookkeeping (slot, fill, drop)
// depends on swmm_pkg (fifo_stat_t); feeds swmm_fifo
`default_nettype none

module swmm_front #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int SLOT_W       = 3,
  parameter int CNT_W        = 4,
  parameter int ENTRY_W      = SAMPLE_BITS + SLOT_W + CNT_W + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_BITS-1:0]  in_sample,
  input  wire swmm_pkg::fifo_stat_t    stat,
  output logic                         push,
  output logic [ENTRY_W-1:0]           push_data
);
  import swmm_pkg::*;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              full_win;

  assign in_stall = stat.full;
  assign push     = in_valid && !in_stall;
  assign full_win = (fill_r == CNT_W'(WINDOW_DEPTH));

  always_comb begin
    slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    fill_nxt = full_win ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
    end else if (push) begin
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entry layout: sample, slot, count after insert, dropped flag
  assign push_data = {in_sample, slot_r, fill_nxt, full_win};

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_DEPTH))
    else $error("swmm_front: fill level above depth");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(WINDOW_DEPTH - 1))
    else $error("swmm_front: write slot out of range");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && full_win |=> fill_r == CNT_W'(WINDOW_DEPTH))
    else $error("swmm_front: fill changed after overwrite");

endmodule

`default_nettype wire

FILE: hw/rtl/swmm_back.sv
// swmm_back: holds the window, finds the median by rank scan and the mean
// with a bit-serial divider; depends on swmm_pkg (back_state_t, fifo_stat_t)
`default_nettype none

module swmm_back #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int SLOT_W       = 3,
  parameter int CNT_W        = 4,
  parameter int ENTRY_W      = SAMPLE_BITS + SLOT_W + CNT_W + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire swmm_pkg::fifo_stat_t   stat,
  output logic                        pop,
  input  wire logic [ENTRY_W-1:0]     pop_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_median_value,
  output logic [SAMPLE_BITS-1:0]      out_mean_value,
  output logic [SAMPLE_BITS-1:0]      out_latest_sample,
  output logic [CNT_W-1:0]            out_window_count,
  output logic                        out_dropped_oldest
);
  import swmm_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int MAG_W = SUM_W - 1;
  localparam int DC_W  = (MAG_W > 1) ? $clog2(MAG_W) : 1;

  back_state_t state_r, state_nxt;

  logic pop_en, scan_en, prep_en, div_en, load_out;

  logic signed [SAMPLE_BITS-1:0] win_r [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rot_r [WINDOW_DEPTH];

  logic signed [SAMPLE_BITS-1:0] e_sample;
  logic [SLOT_W-1:0]             e_slot;
  logic [CNT_W-1:0]              e_count;
  logic                          e_drop;

  logic [SAMPLE_BITS-1:0]  smp_r;
  logic [CNT_W-1:0]        n_r, iter_r;
  logic                    drop_r;
  logic signed [SUM_W-1:0] sum_r;

  logic signed [SAMPLE_BITS-1:0] cand_r;
  logic [WINDOW_DEPTH-1:0]       lt_r, le_r;
  logic                          pa_v_r;
  logic [CNT_W-1:0]              n_less, n_leq;
  logic [SAMPLE_BITS-1:0]        median_r;

  logic              neg_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [DC_W-1:0]   div_cnt_r;
  logic [CNT_W:0]    shifted;
  logic              q_bit;
  logic [SUM_W-1:0]  sum_mag;
  logic [MAG_W-1:0]  quo_signed;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] o_med_r, o_mean_r, o_smp_r;
  logic [CNT_W-1:0]       o_cnt_r;
  logic                   o_drop_r;

  assign {e_sample, e_slot, e_count, e_drop} = pop_data;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!stat.empty) state_nxt = B_SCAN;
      B_SCAN: if (iter_r == n_r - 1'b1) state_nxt = B_PREP;
      B_PREP: state_nxt = B_DIV;
      B_DIV:  if (div_cnt_r == DC_W'(MAG_W - 1)) state_nxt = B_DONE;
      B_DONE: if (!out_valid_r || !out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_en   = 1'b0;
    scan_en  = 1'b0;
    prep_en  = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      B_IDLE: pop_en   = !stat.empty;
      B_SCAN: scan_en  = 1'b1;
      B_PREP: prep_en  = 1'b1;
      B_DIV:  div_en   = 1'b1;
      B_DONE: load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign pop = pop_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window store and rotating copy; the copy shifts down to feed the scan its candidates
  always_ff @(posedge clk) begin
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (pop_en) begin
        if (e_slot == SLOT_W'(k)) begin
          win_r[k] <= e_sample;
          rot_r[k] <= e_sample;
        end else begin
          rot_r[k] <= win_r[k];
        end
      end else if (scan_en && k < WINDOW_DEPTH - 1) begin
        rot_r[k] <= rot_r[k + 1];
      end
    end
  end

  // scan: compare the candidate against every live slot, accumulate the sum
  always_ff @(posedge clk) begin
    if (pop_en) begin
      smp_r  <= e_sample;
      n_r    <= e_count;
      drop_r <= e_drop;
      iter_r <= '0;
      sum_r  <= '0;
    end else if (scan_en) begin
      iter_r <= iter_r + 1'b1;
      sum_r  <= sum_r + SUM_W'(rot_r[0]);
      cand_r <= rot_r[0];
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        lt_r[j] <= (CNT_W'(j) < n_r) && (win_r[j] <  rot_r[0]);
        le_r[j] <= (CNT_W'(j) < n_r) && (win_r[j] <= rot_r[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
    end else begin
      pa_v_r <= scan_en;
    end
  end

  always_comb begin
    n_less = '0;
    n_leq  = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      n_less = n_less + CNT_W'(lt_r[j]);
      n_leq  = n_leq  + CNT_W'(le_r[j]);
    end
  end

  // candidate sits at sorted index count/2 when the ranks bracket it
  always_ff @(posedge clk) begin
    if (pa_v_r && (n_less <= (n_r >> 1)) && (n_leq > (n_r >> 1))) begin
      median_r <= cand_r;
    end
  end

  // restoring divider on the magnitude of the sum, one quotient bit per step in B_DIV
  always_comb begin
    sum_mag    = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    shifted    = {rem_r, quo_r[MAG_W-1]};
    q_bit      = (shifted >= {1'b0, n_r});
    quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (prep_en) begin
      neg_r     <= sum_r[SUM_W-1];
      quo_r     <= sum_mag[MAG_W-1:0];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (div_en) begin
      rem_r     <= q_bit ? CNT_W'(shifted - {1'b0, n_r}) : shifted[CNT_W-1:0];
      quo_r     <= {quo_r[MAG_W-2:0], q_bit};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_med_r  <= median_r;
      o_mean_r <= quo_signed[SAMPLE_BITS-1:0];
      o_smp_r  <= smp_r;
      o_cnt_r  <= n_r;
      o_drop_r <= drop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_value   = o_med_r;
  assign out_mean_value     = o_mean_r;
  assign out_latest_sample  = o_smp_r;
  assign out_window_count   = o_cnt_r;
  assign out_dropped_oldest = o_drop_r;

  a_pop_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> state_r == B_SCAN)
    else $error("swmm_back: pop not followed by scan");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_cnt_r != '0) && (o_cnt_r <= CNT_W'(WINDOW_DEPTH)))
    else $error("swmm_back: window count out of range");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> rem_r < n_r)
    else $error("swmm_back: divider remainder not below divisor");
  a_no_drop_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_drop_r |-> o_cnt_r == CNT_W'(WINDOW_DEPTH))
    else $error("swmm_back: drop flagged on a partial window");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking bench for the sliding-window median and mean filter
// depends on swmm_pkg and sliding_window_median_mean; no files or arguments
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN         = swmm_pkg::DEF_WINDOW_DEPTH;
  localparam int SB          = swmm_pkg::DEF_SAMPLE_BITS;
  localparam int CW          = $clog2(WIN + 1);
  localparam int N_RANDOM    = 430;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 150;
  localparam int DRAIN_WAIT  = 50;

  typedef struct {
    logic signed [SB-1:0] median;
    logic signed [SB-1:0] mean;
    logic signed [SB-1:0] latest;
    logic [CW-1:0]        count;
    logic                 dropped;
  } window_stats_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic signed [SB-1:0] in_sample = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [SB-1:0] out_median_value;
  logic signed [SB-1:0] out_mean_value;
  logic signed [SB-1:0] out_latest_sample;
  logic [CW-1:0]        out_window_count;
  logic                 out_dropped_oldest;

  sliding_window_median_mean i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median_value  (out_median_value),
    .out_mean_value    (out_mean_value),
    .out_latest_sample (out_latest_sample),
    .out_window_count  (out_window_count),
    .out_dropped_oldest(out_dropped_oldest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wire in_beat  = rst_n & in_valid & ~in_stall;
  wire out_beat = rst_n & out_valid & ~out_stall;

  logic signed [SB-1:0] sample_q[$];
  window_stats_t        stats_q[$];
  int                   n_samples  = 0;
  int                   beats_in   = 0;
  int                   beats_out  = 0;
  int                   err_count  = 0;
  logic                 in_taken   = 1'b0;

  // filter state mirrored for prediction
  logic signed [SB-1:0] win_mem[WIN];
  logic [2:0]           win_slot = '0;
  logic [3:0]           win_fill = '0;

  function automatic window_stats_t compute_window_stats(logic signed [SB-1:0] s);
    window_stats_t        r;
    logic signed [SB-1:0] ordered[WIN];
    logic signed [SB-1:0] v;
    longint               total;
    longint               n;
    int                   j;
    r.dropped = (win_fill >= WIN);
    win_mem[win_slot] = s;
    win_slot = (win_slot == WIN - 1) ? '0 : win_slot + 3'd1;
    if (win_fill < WIN) win_fill = win_fill + 4'd1;
    n = win_fill;
    total = 0;
    for (int i = 0; i < n; i++) begin
      v = win_mem[i];
      total += v;
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    r.median = ordered[n/2];
    r.mean   = SB'(total / n);  // truncates toward zero
    r.latest = s;
    r.count  = CW'(n);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    err_count++;
  endtask

  // sender: bursts of random length, random gaps, valid held until taken
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_q.size() != 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall density changes per segment, plus one long hold-off
  int  seg_left  = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && beats_out >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
          endcase
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // monitor: check result beats, predict on input beats
  always @(posedge clk) begin
    window_stats_t want;
    in_taken <= in_beat;
    if (out_beat) begin
      beats_out++;
      if (stats_q.size() == 0) begin
        report_error("result beat with nothing expected");
      end else begin
        want = stats_q.pop_front();
        if (out_median_value !== want.median)
          report_error($sformatf("result %0d median %0d, want %0d",
                                 beats_out, out_median_value, want.median));
        if (out_mean_value !== want.mean)
          report_error($sformatf("result %0d mean %0d, want %0d",
                                 beats_out, out_mean_value, want.mean));
        if (out_latest_sample !== want.latest)
          report_error($sformatf("result %0d latest %0d, want %0d",
                                 beats_out, out_latest_sample, want.latest));
        if (out_window_count !== want.count)
          report_error($sformatf("result %0d count %0d, want %0d",
                                 beats_out, out_window_count, want.count));
        if (out_dropped_oldest !== want.dropped)
          report_error($sformatf("result %0d dropped %0b, want %0b",
                                 beats_out, out_dropped_oldest, want.dropped));
      end
    end
    if (in_beat) begin
      beats_in++;
      void'(sample_q.pop_front());
      stats_q.push_back(compute_window_stats(in_sample));
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || in_beat || out_beat) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int                   drift;
    logic signed [SB-1:0] s;
    // -1 then 0 gives a mean of -0.5, which must truncate to zero
    sample_q = '{-16'sd1, 16'sd0, -16'sd32768, 16'sd32767, 16'sd1, 16'sd32767,
                 16'sd32767, -16'sd32768, -16'sd32768, 16'sd256, -16'sd256,
                 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100,
                 16'sd100, 16'sd100, 16'sd7, 16'sd6, 16'sd5, 16'sd4, -16'sd3};
    drift = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 4))
        0, 1: s = SB'($urandom);
        2: begin
          case ($urandom_range(0, 4))
            0: s = -16'sd32768;
            1: s = 16'sd32767;
            2: s = 16'sd0;
            3: s = -16'sd1;
            default: s = 16'sd1;
          endcase
        end
        default: begin
          // slowly wandering reading with small noise
          drift = drift + $signed($urandom_range(0, 512)) - 256;
          if (drift > 30000 || drift < -30000) drift = 0;
          s = SB'(drift + $signed($urandom_range(0, 64)) - 32);
        end
      endcase
      sample_q.push_back(s);
    end
    n_samples = sample_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_in < n_samples || stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
